/* sv/ttbp_pkg.sv */
`timescale 1ns / 1ps
package ttbp_pkg;
	typedef enum logic [2:0] {
		OP_ALLOC = 3'd0,
		OP_FREE  = 3'd1,
		OP_GET   = 3'd2,
		OP_SET   = 3'd3,
		OP_WRITE = 3'd4,
		OP_MATCH = 3'd5
	} op_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_UNALLOC  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [0:0] REG_EMPTY_DATA = 1'b0;
endpackage

/* sv/ttbp_ram.sv */
`timescale 1ns / 1ps
module ttbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/trie_tail_block_pool_unit.sv */
`timescale 1ns / 1ps
// Allocate, get, set, write and match go from S_CHECK through S_READ and S_FINISH to S_DONE.
// Free passes S_WALK and S_READ once per free-list entry below the freed block, then S_WALK,
// S_FINISH and S_DONE; rejected requests and undefined operations go from S_CHECK to S_DONE,
// and allocate on a full pool from S_READ. One transaction at a time; busy stays high until
// the result strobe, and the link, data and suffix memories pace it with registered reads.
// Reset clears the free-list head, pool count and empty_data (to -1); results cannot stall.
module trie_tail_block_pool_unit
	import ttbp_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024,
	parameter int MAX_SUFFIX = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [0:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         operation,
	input  logic [9:0]         block_index,
	input  logic signed [15:0] data_in,
	input  logic [5:0]         char_position,
	input  logic [7:0]         byte_in,
	output logic               done,
	output logic [2:0]         status,
	output logic [9:0]         block_out,
	output logic signed [15:0] data_out,
	output logic               matched,
	output logic [5:0]         next_position
);
	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int SD = NUM_BLOCKS * MAX_SUFFIX;
	localparam int SW = $clog2(SD);
	localparam int IW = (BW > 10) ? BW : 10;
	localparam int VW = IW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_WALK, S_READ, S_FINISH, S_DONE
	} state_t;

	// Configuration register. The user must write it only while the unit is idle; the block does not enforce this.
	logic [15:0] empty_data_q;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_EMPTY_DATA) ? {16'd0, empty_data_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_data_q <= 16'hFFFF;
		end else if (psel && penable && pwrite && paddr == REG_EMPTY_DATA) begin
			empty_data_q <= pwdata[15:0];
		end
	end

	// The in-use flag of each block rides in bit 16 of the data memory. Every block
	// below the pool count has been written by an allocate, and the range check comes
	// first, so the flags need no clearing at reset.
	logic [BW-1:0]         free_head_q;
	logic [CW-1:0]         count_q;

	state_t        state_q;
	logic [2:0]    op_q;
	logic [IW-1:0] blk_q;
	logic [15:0]   din_q;
	logic [5:0]    pos_q;
	logic [7:0]    byte_q;
	logic [BW-1:0] prev_q;
	logic [BW-1:0] cur_q;

	// Memory ports.
	logic          lk_we, dt_we, sf_we;
	logic [BW-1:0] lk_wa, lk_ra, dt_wa, dt_ra;
	logic [BW-1:0] lk_wd, lk_rd;
	logic [16:0]   dt_wd, dt_rd;
	logic [SW-1:0] sf_wa, sf_ra;
	logic [7:0]    sf_wd, sf_rd;

	ttbp_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
	ttbp_ram #(.WIDTH(17), .DEPTH(NUM_BLOCKS)) u_data (
		.clk(clk), .we(dt_we), .waddr(dt_wa), .wdata(dt_wd), .raddr(dt_ra), .rdata(dt_rd));
	ttbp_ram #(.WIDTH(8), .DEPTH(SD)) u_suffix (
		.clk(clk), .we(sf_we), .waddr(sf_wa), .wdata(sf_wd), .raddr(sf_ra), .rdata(sf_rd));

	logic [BW-1:0] blk_b;
	logic          blk_valid;
	logic [SW-1:0] cell_addr;
	logic          pos_over;
	assign blk_b     = blk_q[BW-1:0];
	assign blk_valid = VW'(count_q) > VW'(blk_q);
	assign cell_addr = SW'(blk_b * MAX_SUFFIX) + SW'(pos_q);
	assign pos_over  = {1'b0, pos_q} >= 7'(MAX_SUFFIX);

	// Reads are issued combinationally. While idle the data memory follows the input
	// index, so the in-use flag of the accepted block is ready in S_CHECK.
	always_comb begin
		lk_ra = (state_q == S_WALK) ? cur_q : free_head_q;
		dt_ra = (state_q == S_IDLE) ? BW'(block_index) : blk_b;
		sf_ra = cell_addr;
	end

	// Walk step: the free list is ascending; stop at the list end or first entry above.
	logic walk_stop;
	assign walk_stop = (cur_q == '0) || (IW'(cur_q) >= blk_q);

	always_comb begin
		lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
		dt_we = 1'b0; dt_wa = blk_b; dt_wd = {1'b0, empty_data_q};
		sf_we = 1'b0; sf_wa = cell_addr; sf_wd = byte_q;
		if (state_q == S_FINISH) begin
			if (op_q == OP_ALLOC) begin
				lk_we = 1'b1; lk_wa = blk_b; lk_wd = '0;
				dt_we = 1'b1; dt_wd = {1'b1, empty_data_q};
				sf_we = 1'b1; sf_wa = SW'(blk_b * MAX_SUFFIX); sf_wd = 8'd0;
			end else if (op_q == OP_FREE) begin
				lk_we = 1'b1; lk_wa = blk_b; lk_wd = cur_q;
				dt_we = 1'b1;
			end else if (op_q == OP_SET) begin
				dt_we = 1'b1; dt_wd = {1'b1, din_q};
			end else if (op_q == OP_WRITE) begin
				sf_we = 1'b1;
			end
		end else if (state_q == S_DONE && op_q == OP_FREE && prev_q != '0) begin
			// Second link write of a free: splice the freed block behind its predecessor.
			lk_we = 1'b1; lk_wa = prev_q; lk_wd = blk_b;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; free_head_q <= '0; count_q <= '0;
			done <= 1'b0; status <= ST_OK; block_out <= '0; data_out <= '0;
			matched <= 1'b0; next_position <= '0;
			op_q <= '0; blk_q <= '0; din_q <= '0; pos_q <= '0; byte_q <= '0;
			prev_q <= '0; cur_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= operation; blk_q <= IW'(block_index); din_q <= data_in;
						pos_q <= char_position; byte_q <= byte_in;
						status <= ST_OK; block_out <= '0; data_out <= empty_data_q;
						matched <= 1'b0; next_position <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					prev_q <= '0; cur_q <= free_head_q;
					if (op_q == OP_MATCH) next_position <= pos_q;
					if (op_q == OP_ALLOC) begin
						state_q <= S_READ;
					end else if (op_q > OP_MATCH) begin
						state_q <= S_DONE;
					end else if (!blk_valid || (op_q == OP_FREE && blk_q == '0)) begin
						status <= ST_RANGE; state_q <= S_DONE;
					end else if (!dt_rd[16]) begin
						status <= ST_UNALLOC; state_q <= S_DONE;
					end else if (op_q == OP_FREE) begin
						state_q <= S_WALK;
					end else if (op_q == OP_WRITE && (pos_over ||
						({1'b0, pos_q} == 7'(MAX_SUFFIX - 1) && byte_q != 8'd0))) begin
						status <= ST_OVERFLOW; state_q <= S_DONE;
					end else if (op_q == OP_MATCH && pos_over) begin
						status <= ST_OVERFLOW; state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_WALK: begin
					// Link read of cur_q is issued this cycle; consumed in S_READ.
					if (walk_stop) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (op_q == OP_FREE) begin
						prev_q <= cur_q; cur_q <= lk_rd; state_q <= S_WALK;
					end else if (op_q == OP_ALLOC) begin
						if (free_head_q != '0) begin
							blk_q <= IW'(free_head_q); free_head_q <= lk_rd;
							state_q <= S_FINISH;
						end else if (count_q < CW'(NUM_BLOCKS)) begin
							blk_q <= IW'(count_q); count_q <= count_q + 1'b1;
							state_q <= S_FINISH;
						end else begin
							status <= ST_FULL; state_q <= S_DONE;
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (op_q == OP_ALLOC) begin
						block_out <= blk_q[9:0];
					end else if (op_q == OP_FREE) begin
						if (prev_q == '0) free_head_q <= blk_b;
					end else if (op_q == OP_GET) begin
						data_out <= dt_rd[15:0];
					end else if (op_q == OP_MATCH && sf_rd == byte_q) begin
						matched <= 1'b1;
						if (sf_rd != 8'd0) next_position <= pos_q + 6'd1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result strobe comes only at the end of a transaction.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	// Accepting a transaction raises busy.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	// The pool count never exceeds the pool size.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_BLOCKS)) else $error("pool count overflow");
	// A successful allocate marks its block as in use.
	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && op_q == OP_ALLOC) |-> (dt_we && dt_wd[16]))
		else $error("allocated block not marked");
endmodule

/* tb/trie_tail_block_pool_unit_test.sv */
`timescale 1ns / 1ps
module trie_tail_block_pool_unit_test;
	import ttbp_pkg::*;

	localparam int POOL_SIZE = 1024;
	localparam int SUFFIX_LEN = 64;
	localparam int STALL_LIMIT = 50000;

	// The two undefined operation codes, which must leave the pool untouched.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]         op;
		logic [9:0]         blk;
		logic signed [15:0] din;
		logic [5:0]         pos;
		logic [7:0]         chr;
		int                 gap;
	} pool_cmd_t;

	typedef struct {
		logic [2:0]         status;
		logic [9:0]         blk;
		logic signed [15:0] data;
		logic               matched;
		logic [5:0]         npos;
	} pool_reply_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [0:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic [2:0]         operation;
	logic [9:0]         block_index;
	logic signed [15:0] data_in;
	logic [5:0]         char_position;
	logic [7:0]         byte_in;
	logic               done;
	logic [2:0]         status;
	logic [9:0]         block_out;
	logic signed [15:0] data_out;
	logic               matched;
	logic [5:0]         next_position;

	trie_tail_block_pool_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.operation(operation), .block_index(block_index), .data_in(data_in),
		.char_position(char_position), .byte_in(byte_in),
		.done(done), .status(status), .block_out(block_out), .data_out(data_out),
		.matched(matched), .next_position(next_position)
	);

	// Shadow copy of the pool. It is updated at the clock edge that accepts a
	// transaction, so it always reflects every command the block has taken.
	logic [9:0]         link_mem [POOL_SIZE];
	logic signed [15:0] word_mem [POOL_SIZE];
	logic [7:0]         tail_mem [POOL_SIZE*SUFFIX_LEN];
	bit                 tail_written [POOL_SIZE*SUFFIX_LEN];
	bit                 taken [POOL_SIZE];
	logic [9:0]         head_free;
	int                 pool_used;
	logic signed [15:0] blank_word;

	pool_cmd_t   cmd_queue[$];
	pool_reply_t reply_queue[$];
	int          fail_count;
	int          wait_left;
	bit          gap_loaded;
	int          quiet_cycles;
	bit          burst;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Work out the reply to one accepted command and advance the shadow pool.
	function automatic pool_reply_t apply_command(pool_cmd_t c);
		pool_reply_t r;
		int          b;
		int          prev;
		int          cur;
		int          steps;
		bit          in_range;
		r.status = ST_OK;
		r.blk = '0;
		r.data = blank_word;
		r.matched = 1'b0;
		r.npos = '0;
		in_range = int'(c.blk) < pool_used;
		if (c.op == OP_ALLOC) begin
			b = -1;
			if (head_free != 0) begin
				b = int'(head_free);
				head_free = link_mem[b];
			end else if (pool_used < POOL_SIZE) begin
				b = pool_used;
				pool_used++;
			end else begin
				r.status = ST_FULL;
			end
			if (b >= 0) begin
				taken[b] = 1'b1;
				link_mem[b] = '0;
				word_mem[b] = blank_word;
				tail_mem[b*SUFFIX_LEN] = '0;
				tail_written[b*SUFFIX_LEN] = 1'b1;
				r.blk = b[9:0];
			end
		end else if (c.op >= OP_FREE && c.op <= OP_MATCH) begin
			if (c.op == OP_MATCH)
				r.npos = c.pos;
			if (!in_range || (c.op == OP_FREE && c.blk == 0)) begin
				r.status = ST_RANGE;
			end else if (!taken[c.blk]) begin
				r.status = ST_UNALLOC;
			end else begin
				case (c.op)
					OP_FREE: begin
						// Sorted insertion: walk past every free block below this one.
						prev = 0;
						cur = int'(head_free);
						steps = 0;
						while (cur != 0 && cur < c.blk && steps < POOL_SIZE) begin
							prev = cur;
							cur = int'(link_mem[cur]);
							steps++;
						end
						taken[c.blk] = 1'b0;
						word_mem[c.blk] = blank_word;
						link_mem[c.blk] = cur[9:0];
						if (prev != 0)
							link_mem[prev] = c.blk;
						else
							head_free = c.blk;
					end
					OP_GET: r.data = word_mem[c.blk];
					OP_SET: word_mem[c.blk] = c.din;
					OP_WRITE: begin
						if (c.pos == SUFFIX_LEN - 1 && c.chr != 0) begin
							r.status = ST_OVERFLOW;
						end else begin
							tail_mem[c.blk*SUFFIX_LEN + c.pos] = c.chr;
							tail_written[c.blk*SUFFIX_LEN + c.pos] = 1'b1;
						end
					end
					default: begin
						if (tail_mem[c.blk*SUFFIX_LEN + c.pos] == c.chr) begin
							r.matched = 1'b1;
							if (c.chr != 0)
								r.npos = c.pos + 6'd1;
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	// Driver: each command waits out its own gap, then start is held until
	// the block accepts the transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			operation <= OP_ALLOC;
			block_index <= '0;
			data_in <= '0;
			char_position <= '0;
			byte_in <= '0;
			wait_left <= 0;
			gap_loaded <= 1'b0;
		end else if (start) begin
			if (!busy)
				start <= 1'b0;
		end else if (wait_left > 0) begin
			wait_left <= wait_left - 1;
		end else if (cmd_queue.size() > 0) begin
			if (!gap_loaded && cmd_queue[0].gap > 0) begin
				wait_left <= cmd_queue[0].gap - 1;
				gap_loaded <= 1'b1;
			end else begin
				operation <= cmd_queue[0].op;
				block_index <= cmd_queue[0].blk;
				data_in <= cmd_queue[0].din;
				char_position <= cmd_queue[0].pos;
				byte_in <= cmd_queue[0].chr;
				start <= 1'b1;
				gap_loaded <= 1'b0;
				void'(cmd_queue.pop_front());
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: retires results first, then models any transaction accepted
	// at the same edge, and tracks register writes on the APB port.
	always @(posedge clk) begin
		pool_reply_t want;
		pool_cmd_t   c;
		if (arst_n) begin
			if (done) begin
				if (reply_queue.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d",
						$realtime, status);
					fail_count++;
				end else begin
					want = reply_queue.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("block_out", 16'(want.blk), 16'(block_out));
					check_field("data_out", want.data, data_out);
					check_field("matched", 16'(want.matched), 16'(matched));
					check_field("next_position", 16'(want.npos), 16'(next_position));
				end
			end
			if (start && !busy) begin
				c.op = operation;
				c.blk = block_index;
				c.din = data_in;
				c.pos = char_position;
				c.chr = byte_in;
				c.gap = 0;
				reply_queue.push_back(apply_command(c));
			end
			if (psel && penable && pwrite && pready && paddr == REG_EMPTY_DATA)
				blank_word = pwdata[15:0];
			if (done || (start && !busy) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog on cycles with no result, no accepted command and no APB access.
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Queue one command and wait until the block has accepted it, so that the
	// shadow pool is current when the next command is chosen.
	task automatic send(logic [2:0] op, logic [9:0] blk, logic signed [15:0] din,
		logic [5:0] pos, logic [7:0] chr);
		pool_cmd_t c;
		c.op = op;
		c.blk = blk;
		c.din = din;
		c.pos = pos;
		c.chr = chr;
		if ($urandom_range(0, 99) < 3)
			burst = !burst;
		c.gap = burst ? 0 : $urandom_range(0, 19);
		cmd_queue.push_back(c);
		do @(negedge clk); while (cmd_queue.size() != 0 || start);
	endtask

	// Hold the sender until every outstanding result has been seen.
	task automatic drain();
		do @(negedge clk); while (reply_queue.size() != 0 || busy || start);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_blank(logic signed [15:0] value);
		drain();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_EMPTY_DATA;
		pwdata <= {{16{value[15]}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly well-formed traffic: blocks are picked among allocated ones and
	// matches only look at suffix cells that have been written.
	task automatic random_command(bit alloc_only);
		logic [2:0] op;
		logic [9:0] blk;
		logic [5:0] pos;
		logic [7:0] chr;
		int         pick;
		int         tries;
		pick = $urandom_range(0, 99);
		if (alloc_only || pick < 14) op = OP_ALLOC;
		else if (pick < 26) op = OP_FREE;
		else if (pick < 38) op = OP_GET;
		else if (pick < 52) op = OP_SET;
		else if (pick < 76) op = OP_WRITE;
		else if (pick < 98) op = OP_MATCH;
		else op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
		blk = 10'($urandom_range(0, POOL_SIZE - 1));
		if (pool_used > 0 && $urandom_range(0, 99) < 88) begin
			tries = 0;
			do begin
				blk = 10'($urandom_range(0, pool_used - 1));
				tries++;
			end while (!taken[blk] && tries < 10);
		end
		pos = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 7))
			: 6'($urandom_range(0, 63));
		chr = ($urandom_range(0, 99) < 25) ? 8'd0 : 8'($urandom_range(0, 255));
		if (op == OP_MATCH && int'(blk) < pool_used && taken[blk]) begin
			if (!tail_written[blk*SUFFIX_LEN + pos])
				pos = '0;
			if ($urandom_range(0, 1))
				chr = tail_mem[blk*SUFFIX_LEN + pos];
		end
		send(op, blk, 16'($urandom_range(0, 65535)), pos, chr);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = REG_EMPTY_DATA;
		pwdata = '0;
		fail_count = 0;
		quiet_cycles = 0;
		burst = 1'b0;
		head_free = '0;
		pool_used = 0;
		blank_word = -16'sd1;
		foreach (taken[i]) taken[i] = 1'b0;
		foreach (tail_written[i]) tail_written[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, run with the reset value of empty_data.
		send(OP_ALLOC, '0, '0, '0, '0);
		send(OP_ALLOC, '0, '0, '0, '0);
		send(OP_ALLOC, '0, '0, '0, '0);
		send(OP_GET, 10'd1, '0, '0, '0);
		send(OP_SET, 10'd1, -16'sd32768, '0, '0);
		send(OP_GET, 10'd1, '0, '0, '0);
		send(OP_SET, 10'd2, 16'sd32767, '0, '0);
		send(OP_GET, 10'd2, '0, '0, '0);
		send(OP_WRITE, 10'd1, '0, 6'd0, 8'hFF);
		send(OP_WRITE, 10'd1, '0, 6'd1, 8'h00);
		send(OP_MATCH, 10'd1, '0, 6'd0, 8'hFF);
		send(OP_MATCH, 10'd1, '0, 6'd1, 8'h00);
		send(OP_MATCH, 10'd1, '0, 6'd0, 8'h41);
		// A nonzero byte in the last cell leaves no room for the terminator.
		send(OP_WRITE, 10'd2, '0, 6'd63, 8'h5A);
		send(OP_WRITE, 10'd2, '0, 6'd63, 8'h00);
		send(OP_MATCH, 10'd2, '0, 6'd63, 8'h00);
		send(OP_FREE, 10'd0, '0, '0, '0);
		send(OP_FREE, 10'd2, '0, '0, '0);
		send(OP_FREE, 10'd1, '0, '0, '0);
		send(OP_FREE, 10'd1, '0, '0, '0);
		send(OP_GET, 10'd2, '0, '0, '0);
		send(OP_GET, 10'd1023, '0, '0, '0);
		send(OP_SPARE_LO, 10'd1023, -16'sd1, 6'd63, 8'hFF);
		send(OP_SPARE_HI, '0, '0, '0, '0);
		send(OP_ALLOC, '0, '0, '0, '0);

		// Random traffic at the most negative empty_data.
		write_blank(-16'sd32768);
		repeat (200) random_command(1'b0);

		write_blank(16'sd32767);
		repeat (225) random_command(1'b0);

		write_blank(16'sd0);
		repeat (225) random_command(1'b0);

		write_blank(16'($urandom_range(0, 65535)));
		repeat (225) random_command(1'b0);

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && reply_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* trie_tail_block_pool_unit.f */
sv/ttbp_pkg.sv
sv/ttbp_ram.sv
sv/trie_tail_block_pool_unit.sv
tb/trie_tail_block_pool_unit_test.sv
